### rtl/hebb_pkg.sv
// ----------------------------------------------------------------------------
// hebb_pkg
// Shared constants, types and helpers of the Hebbian associative memory.
// ----------------------------------------------------------------------------
package hebb_pkg;

   localparam int VEC_LEN  = 4;
   localparam int IDX_W    = $clog2(VEC_LEN);
   localparam int ADDR_W   = 2 * IDX_W;

   localparam int ELEM_W   = 8;
   localparam int WEIGHT_W = 32;
   localparam int RECALL_W = 48;
   localparam int SIM_W    = 16;

   localparam int DOT_W    = 51;
   localparam int VNORM_W  = 17;
   localparam int RNORM_W  = 83;
   localparam int LNUM_W   = 99;
   localparam int ACC_W    = 132;
   localparam int MUL_W    = 32;
   localparam int SHIFT_W  = 7;
   localparam int PART_W   = 2;
   localparam int BIT_W    = 5;
   localparam int QUOT_W   = 31;
   localparam int ROOT_W   = 16;

   localparam logic OP_TEACH = 1'b0;
   localparam logic OP_CHECK = 1'b1;

   localparam logic [SHIFT_W-1:0] SH_NONE      = 7'd0;
   localparam logic [SHIFT_W-1:0] SH_LIMB      = 7'd32;
   localparam logic [SHIFT_W-1:0] SH_CROSS     = 7'd33;
   localparam logic [SHIFT_W-1:0] SH_HIGH      = 7'd64;
   localparam logic [SHIFT_W-1:0] SH_DOT_LO    = 7'd30;
   localparam logic [SHIFT_W-1:0] SH_DOT_CROSS = 7'd63;
   localparam logic [SHIFT_W-1:0] SH_DOT_HIGH  = 7'd94;

   localparam logic [PART_W-1:0] PART_LO    = 2'd0;
   localparam logic [PART_W-1:0] PART_CROSS = 2'd1;
   localparam logic [PART_W-1:0] PART_HIGH  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TEACH,
      ST_ROW,
      ST_DOT,
      ST_VNORM,
      ST_RNORM,
      ST_LNUM,
      ST_RDEN,
      ST_CHECK,
      ST_DIV,
      ST_SQRT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                use_ext;
      logic                sub;
      logic [SHIFT_W-1:0]  shift;
   } unit_ctl_type;

   function automatic logic [ELEM_W-1:0] elem_mag(input logic [ELEM_W-1:0] x);
      return x[ELEM_W-1] ? (~x + 1'b1) : x;
   endfunction

endpackage

### rtl/hebb_chan_if.sv
// ----------------------------------------------------------------------------
// hebb_chan_if
// Request and response channels of the Hebbian associative memory.
// ----------------------------------------------------------------------------
interface hebb_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 operation;
   logic signed [hebb_pkg::ELEM_W-1:0]   elem_0;
   logic signed [hebb_pkg::ELEM_W-1:0]   elem_1;
   logic signed [hebb_pkg::ELEM_W-1:0]   elem_2;
   logic signed [hebb_pkg::ELEM_W-1:0]   elem_3;

   modport source (output valid, operation, elem_0, elem_1, elem_2, elem_3,
                   input ready);
   modport sink   (input valid, operation, elem_0, elem_1, elem_2, elem_3,
                   output ready);
endinterface

interface hebb_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [hebb_pkg::RECALL_W-1:0] recall_0;
   logic signed [hebb_pkg::RECALL_W-1:0] recall_1;
   logic signed [hebb_pkg::RECALL_W-1:0] recall_2;
   logic signed [hebb_pkg::RECALL_W-1:0] recall_3;
   logic signed [hebb_pkg::SIM_W-1:0]    similarity;
   logic                                 zero_norm;

   modport source (output valid, recall_0, recall_1, recall_2, recall_3,
                   similarity, zero_norm, input ready);
   modport sink   (input valid, recall_0, recall_1, recall_2, recall_3,
                   similarity, zero_norm, output ready);
endinterface

### rtl/hebbian_associative_memory_unit.sv
// ----------------------------------------------------------------------------
// hebbian_associative_memory_unit
// 4x4 Hebbian associative memory: teach accumulates outer products, check
// gives recall W*v and its Q1.15 cosine similarity with the probe.
// ----------------------------------------------------------------------------
//  channel   dir  transfer when        payload
//  req_chan  in   valid && ready       operation, elem_0..elem_3
//  rsp_chan  out  valid && ready       recall_0..recall_3, similarity, zero_norm
//
//  Teach writes one weight per cycle; check runs through these steps:
//  16 row MACs, 30 norm/dot partial products, 31 divide steps, 16 root steps,
//  plus accept, zero test and output states; a zero norm skips divide and
//  root. All through one 32x32 multiplier and one 132-bit adder.
//  Reset clears the weights and the control state.
//  A finished result waits in the output register; the next request is taken
//  meanwhile, and a second check stalls only at its end until the slot frees.
// ----------------------------------------------------------------------------
module hebbian_associative_memory_unit (
   input  logic       clock,
   input  logic       reset,
   hebb_req_if.sink   req_chan,
   hebb_rsp_if.source rsp_chan
);

   localparam int N  = hebb_pkg::VEC_LEN;
   localparam int AW = hebb_pkg::ACC_W;

   hebb_pkg::state_type state_ff, state_in;
   logic [hebb_pkg::IDX_W-1:0]  row_ff, row_in, col_ff, col_in;
   logic [hebb_pkg::PART_W-1:0] part_ff, part_in;
   logic [hebb_pkg::BIT_W-1:0]  bit_ff, bit_in;

   logic [hebb_pkg::ELEM_W-1:0] vr_ff [N];
   logic [hebb_pkg::ELEM_W-1:0] vr_in [N];
   logic [hebb_pkg::ELEM_W-1:0] vc_ff [N];
   logic [hebb_pkg::ELEM_W-1:0] vc_in [N];
   logic [hebb_pkg::RECALL_W-1:0] r_ff [N];
   logic [hebb_pkg::RECALL_W-1:0] r_in [N];

   logic signed [AW-1:0]          acc_ff, acc_in;
   logic [hebb_pkg::DOT_W-1:0]    dot_ff, dot_in;
   logic [hebb_pkg::VNORM_W-1:0]  vnorm_ff, vnorm_in;
   logic [hebb_pkg::RNORM_W-1:0]  rnorm_ff, rnorm_in;
   logic [hebb_pkg::LNUM_W-1:0]   lnum_ff, lnum_in;
   logic [hebb_pkg::QUOT_W-1:0]   quot_ff, quot_in;
   logic [hebb_pkg::ROOT_W-1:0]   root_ff, root_in;
   logic                          zero_ff, zero_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [hebb_pkg::RECALL_W-1:0] rsp_recall_ff [N];
   logic [hebb_pkg::RECALL_W-1:0] rsp_recall_in [N];
   logic [hebb_pkg::SIM_W-1:0]    rsp_sim_ff, rsp_sim_in;
   logic                          rsp_zero_ff, rsp_zero_in;

   logic [hebb_pkg::MUL_W-1:0]    mul_a, mul_b;
   hebb_pkg::unit_ctl_type        ctl;
   logic [AW-1:0]                 ext;
   logic signed [AW-1:0]          unit_acc, sum;

   logic                                 wr_en;
   logic signed [hebb_pkg::WEIGHT_W-1:0] wr_data, w_rd;
   logic [hebb_pkg::WEIGHT_W-1:0]        w_mag;
   logic [hebb_pkg::ELEM_W-1:0]          vr_mag, vc_mag;
   logic [hebb_pkg::RECALL_W-1:0]        r_sel, r_mag;
   logic [hebb_pkg::DOT_W-1:0]           d_mag;
   logic [AW-hebb_pkg::WEIGHT_W:0]       upper;
   logic [hebb_pkg::ROOT_W-1:0]          trial;
   logic [hebb_pkg::SIM_W-1:0]           sim;
   logic                                 load;
   logic                                 row_last, col_last;

   hebb_weights u_weights (
      .clock   (clock),
      .reset   (reset),
      .addr    ({row_ff, col_ff}),
      .wr_en   (wr_en),
      .wr_data (wr_data),
      .rd_data (w_rd)
   );

   hebb_unit u_unit (
      .mul_a (mul_a),
      .mul_b (mul_b),
      .ctl   (ctl),
      .ext   (ext),
      .acc   (unit_acc),
      .sum   (sum)
   );

   assign req_chan.ready = (state_ff == hebb_pkg::ST_IDLE);

   always_comb begin
      vr_mag   = hebb_pkg::elem_mag(vr_ff[0]);
      vc_mag   = hebb_pkg::elem_mag(vc_ff[0]);
      w_mag    = w_rd[hebb_pkg::WEIGHT_W-1] ? (~w_rd + 1'b1) : w_rd;
      r_sel    = r_ff[row_ff];
      r_mag    = r_sel[hebb_pkg::RECALL_W-1] ? (~r_sel + 1'b1) : r_sel;
      d_mag    = dot_ff[hebb_pkg::DOT_W-1] ? (~dot_ff + 1'b1) : dot_ff;
      row_last = (row_ff == hebb_pkg::IDX_W'(N-1));
      col_last = (col_ff == hebb_pkg::IDX_W'(N-1));
      trial    = root_ff | (hebb_pkg::ROOT_W'(1) << bit_ff[$clog2(hebb_pkg::ROOT_W)-1:0]);

      upper    = sum[AW-1:hebb_pkg::WEIGHT_W-1];
      if ((&upper) || (~|upper)) begin
         wr_data = sum[hebb_pkg::WEIGHT_W-1:0];
      end else if (sum[AW-1]) begin
         wr_data = {1'b1, {(hebb_pkg::WEIGHT_W-1){1'b0}}};
      end else begin
         wr_data = {1'b0, {(hebb_pkg::WEIGHT_W-1){1'b1}}};
      end

      if (zero_ff) begin
         sim = '0;
      end else if (dot_ff[hebb_pkg::DOT_W-1]) begin
         sim = ~root_ff + 1'b1;
      end else if (root_ff[hebb_pkg::ROOT_W-1]) begin
         sim = {1'b0, {(hebb_pkg::SIM_W-1){1'b1}}};
      end else begin
         sim = root_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      part_in  = part_ff;
      bit_in   = bit_ff;
      vr_in    = vr_ff;
      vc_in    = vc_ff;
      r_in     = r_ff;
      acc_in   = acc_ff;
      dot_in   = dot_ff;
      vnorm_in = vnorm_ff;
      rnorm_in = rnorm_ff;
      lnum_in  = lnum_ff;
      quot_in  = quot_ff;
      root_in  = root_ff;
      zero_in  = zero_ff;
      mul_a    = '0;
      mul_b    = '0;
      ctl      = '0;
      ext      = '0;
      unit_acc = acc_ff;
      wr_en    = 1'b0;
      load     = 1'b0;

      case (state_ff)
         hebb_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               vr_in[0] = req_chan.elem_0;
               vr_in[1] = req_chan.elem_1;
               vr_in[2] = req_chan.elem_2;
               vr_in[3] = req_chan.elem_3;
               vc_in    = vr_in;
               row_in   = '0;
               col_in   = '0;
               part_in  = hebb_pkg::PART_LO;
               acc_in   = '0;
               zero_in  = 1'b0;
               state_in = (req_chan.operation == hebb_pkg::OP_CHECK) ? hebb_pkg::ST_ROW
                                                                     : hebb_pkg::ST_TEACH;
            end
         end
         hebb_pkg::ST_TEACH: begin
            mul_a    = hebb_pkg::MUL_W'(vr_mag);
            mul_b    = hebb_pkg::MUL_W'(vc_mag);
            ctl.sub  = vr_ff[0][hebb_pkg::ELEM_W-1] ^ vc_ff[0][hebb_pkg::ELEM_W-1];
            unit_acc = {{(AW-hebb_pkg::WEIGHT_W){w_rd[hebb_pkg::WEIGHT_W-1]}}, w_rd};
            wr_en    = 1'b1;
            for (int i = 0; i < N; i++) vc_in[i] = vc_ff[(i+1) % N];
            col_in   = col_ff + 1'b1;
            if (col_last) begin
               for (int i = 0; i < N; i++) vr_in[i] = vr_ff[(i+1) % N];
               row_in = row_ff + 1'b1;
               if (row_last) state_in = hebb_pkg::ST_IDLE;
            end
         end
         hebb_pkg::ST_ROW: begin
            mul_a   = w_mag;
            mul_b   = hebb_pkg::MUL_W'(vc_mag);
            ctl.sub = w_rd[hebb_pkg::WEIGHT_W-1] ^ vc_ff[0][hebb_pkg::ELEM_W-1];
            acc_in  = sum;
            for (int i = 0; i < N; i++) vc_in[i] = vc_ff[(i+1) % N];
            col_in  = col_ff + 1'b1;
            if (col_last) begin
               r_in[row_ff] = sum[hebb_pkg::RECALL_W-1:0];
               acc_in       = '0;
               row_in       = row_ff + 1'b1;
               if (row_last) state_in = hebb_pkg::ST_DOT;
            end
         end
         hebb_pkg::ST_DOT: begin
            mul_a     = (part_ff == hebb_pkg::PART_LO) ? r_mag[31:0]
                                                      : hebb_pkg::MUL_W'(r_mag[47:32]);
            mul_b     = hebb_pkg::MUL_W'(vr_mag);
            ctl.shift = (part_ff == hebb_pkg::PART_LO) ? hebb_pkg::SH_NONE : hebb_pkg::SH_LIMB;
            ctl.sub   = r_sel[hebb_pkg::RECALL_W-1] ^ vr_ff[0][hebb_pkg::ELEM_W-1];
            acc_in    = sum;
            if (part_ff == hebb_pkg::PART_LO) begin
               part_in = hebb_pkg::PART_CROSS;
            end else begin
               part_in = hebb_pkg::PART_LO;
               for (int i = 0; i < N; i++) vr_in[i] = vr_ff[(i+1) % N];
               row_in  = row_ff + 1'b1;
               if (row_last) begin
                  dot_in   = sum[hebb_pkg::DOT_W-1:0];
                  acc_in   = '0;
                  state_in = hebb_pkg::ST_VNORM;
               end
            end
         end
         hebb_pkg::ST_VNORM: begin
            mul_a  = hebb_pkg::MUL_W'(vr_mag);
            mul_b  = hebb_pkg::MUL_W'(vr_mag);
            acc_in = sum;
            for (int i = 0; i < N; i++) vr_in[i] = vr_ff[(i+1) % N];
            row_in = row_ff + 1'b1;
            if (row_last) begin
               vnorm_in = sum[hebb_pkg::VNORM_W-1:0];
               acc_in   = '0;
               state_in = hebb_pkg::ST_RNORM;
            end
         end
         hebb_pkg::ST_RNORM: begin
            case (part_ff)
               hebb_pkg::PART_LO: begin
                  mul_a = r_mag[31:0];
                  mul_b = r_mag[31:0];
               end
               hebb_pkg::PART_CROSS: begin
                  mul_a     = r_mag[31:0];
                  mul_b     = hebb_pkg::MUL_W'(r_mag[47:32]);
                  ctl.shift = hebb_pkg::SH_CROSS;
               end
               default: begin
                  mul_a     = hebb_pkg::MUL_W'(r_mag[47:32]);
                  mul_b     = hebb_pkg::MUL_W'(r_mag[47:32]);
                  ctl.shift = hebb_pkg::SH_HIGH;
               end
            endcase
            acc_in = sum;
            if (part_ff == hebb_pkg::PART_HIGH) begin
               part_in = hebb_pkg::PART_LO;
               row_in  = row_ff + 1'b1;
               if (row_last) begin
                  rnorm_in = sum[hebb_pkg::RNORM_W-1:0];
                  acc_in   = '0;
                  state_in = hebb_pkg::ST_LNUM;
               end
            end else begin
               part_in = part_ff + 1'b1;
            end
         end
         hebb_pkg::ST_LNUM: begin
            mul_a = hebb_pkg::MUL_W'(vnorm_ff);
            case (part_ff)
               hebb_pkg::PART_LO: begin
                  mul_b = rnorm_ff[31:0];
               end
               hebb_pkg::PART_CROSS: begin
                  mul_b     = rnorm_ff[63:32];
                  ctl.shift = hebb_pkg::SH_LIMB;
               end
               default: begin
                  mul_b     = hebb_pkg::MUL_W'(rnorm_ff[hebb_pkg::RNORM_W-1:64]);
                  ctl.shift = hebb_pkg::SH_HIGH;
               end
            endcase
            acc_in = sum;
            if (part_ff == hebb_pkg::PART_HIGH) begin
               lnum_in  = sum[hebb_pkg::LNUM_W-1:0];
               acc_in   = '0;
               part_in  = hebb_pkg::PART_LO;
               state_in = hebb_pkg::ST_RDEN;
            end else begin
               part_in = part_ff + 1'b1;
            end
         end
         hebb_pkg::ST_RDEN: begin
            case (part_ff)
               hebb_pkg::PART_LO: begin
                  mul_a     = d_mag[31:0];
                  mul_b     = d_mag[31:0];
                  ctl.shift = hebb_pkg::SH_DOT_LO;
               end
               hebb_pkg::PART_CROSS: begin
                  mul_a     = d_mag[31:0];
                  mul_b     = hebb_pkg::MUL_W'(d_mag[hebb_pkg::DOT_W-1:32]);
                  ctl.shift = hebb_pkg::SH_DOT_CROSS;
               end
               default: begin
                  mul_a     = hebb_pkg::MUL_W'(d_mag[hebb_pkg::DOT_W-1:32]);
                  mul_b     = hebb_pkg::MUL_W'(d_mag[hebb_pkg::DOT_W-1:32]);
                  ctl.shift = hebb_pkg::SH_DOT_HIGH;
               end
            endcase
            acc_in = sum;
            if (part_ff == hebb_pkg::PART_HIGH) begin
               part_in  = hebb_pkg::PART_LO;
               state_in = hebb_pkg::ST_CHECK;
            end else begin
               part_in = part_ff + 1'b1;
            end
         end
         hebb_pkg::ST_CHECK: begin
            if ((vnorm_ff == '0) || (rnorm_ff == '0)) begin
               zero_in  = 1'b1;
               state_in = hebb_pkg::ST_OUT;
            end else begin
               bit_in   = hebb_pkg::BIT_W'(hebb_pkg::QUOT_W-1);
               quot_in  = '0;
               state_in = hebb_pkg::ST_DIV;
            end
         end
         hebb_pkg::ST_DIV: begin
            ctl.use_ext = 1'b1;
            ctl.sub     = 1'b1;
            ctl.shift   = hebb_pkg::SHIFT_W'(bit_ff);
            ext         = AW'(lnum_ff);
            if (!sum[AW-1]) begin
               acc_in          = sum;
               quot_in[bit_ff] = 1'b1;
            end
            if (bit_ff == '0) begin
               bit_in   = hebb_pkg::BIT_W'(hebb_pkg::ROOT_W-1);
               root_in  = '0;
               state_in = hebb_pkg::ST_SQRT;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         hebb_pkg::ST_SQRT: begin
            mul_a    = hebb_pkg::MUL_W'(trial);
            mul_b    = hebb_pkg::MUL_W'(trial);
            ctl.sub  = 1'b1;
            unit_acc = AW'(quot_ff);
            if (!sum[AW-1]) root_in = trial;
            if (bit_ff == '0) begin
               state_in = hebb_pkg::ST_OUT;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         hebb_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load     = 1'b1;
               state_in = hebb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hebb_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff & ~rsp_chan.ready;
      rsp_recall_in = rsp_recall_ff;
      rsp_sim_in    = rsp_sim_ff;
      rsp_zero_in   = rsp_zero_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_recall_in = r_ff;
         rsp_sim_in    = sim;
         rsp_zero_in   = zero_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hebb_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff        <= row_in;
      col_ff        <= col_in;
      part_ff       <= part_in;
      bit_ff        <= bit_in;
      vr_ff         <= vr_in;
      vc_ff         <= vc_in;
      r_ff          <= r_in;
      acc_ff        <= acc_in;
      dot_ff        <= dot_in;
      vnorm_ff      <= vnorm_in;
      rnorm_ff      <= rnorm_in;
      lnum_ff       <= lnum_in;
      quot_ff       <= quot_in;
      root_ff       <= root_in;
      zero_ff       <= zero_in;
      rsp_recall_ff <= rsp_recall_in;
      rsp_sim_ff    <= rsp_sim_in;
      rsp_zero_ff   <= rsp_zero_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.recall_0   = rsp_recall_ff[0];
   assign rsp_chan.recall_1   = rsp_recall_ff[1];
   assign rsp_chan.recall_2   = rsp_recall_ff[2];
   assign rsp_chan.recall_3   = rsp_recall_ff[3];
   assign rsp_chan.similarity = rsp_sim_ff;
   assign rsp_chan.zero_norm  = rsp_zero_ff;

endmodule

### rtl/hebb_unit.sv
// ----------------------------------------------------------------------------
// hebb_unit
// Shared multiply / shift / add-subtract unit used by the teach, recall, norm, divide and root steps.
// ----------------------------------------------------------------------------
module hebb_unit (
   input  logic [hebb_pkg::MUL_W-1:0]        mul_a,
   input  logic [hebb_pkg::MUL_W-1:0]        mul_b,
   input  hebb_pkg::unit_ctl_type            ctl,
   input  logic [hebb_pkg::ACC_W-1:0]        ext,
   input  logic signed [hebb_pkg::ACC_W-1:0] acc,
   output logic signed [hebb_pkg::ACC_W-1:0] sum
);

   logic [2*hebb_pkg::MUL_W-1:0] prod;
   logic [hebb_pkg::ACC_W-1:0]   base;
   logic [hebb_pkg::ACC_W-1:0]   addend;

   always_comb begin
      prod   = (2*hebb_pkg::MUL_W)'(mul_a) * (2*hebb_pkg::MUL_W)'(mul_b);
      base   = ctl.use_ext ? ext
                           : {{(hebb_pkg::ACC_W-2*hebb_pkg::MUL_W){1'b0}}, prod};
      addend = base << ctl.shift;
      sum    = ctl.sub ? (acc - $signed(addend)) : (acc + $signed(addend));
   end

endmodule

### rtl/hebb_weights.sv
// ----------------------------------------------------------------------------
// hebb_weights
// Weight matrix storage, cleared by reset, one address shared by a combinational read and a write port.
// ----------------------------------------------------------------------------
module hebb_weights (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [hebb_pkg::ADDR_W-1:0]           addr,
   input  logic                                  wr_en,
   input  logic signed [hebb_pkg::WEIGHT_W-1:0]  wr_data,
   output logic signed [hebb_pkg::WEIGHT_W-1:0]  rd_data
);

   localparam int DEPTH = hebb_pkg::VEC_LEN * hebb_pkg::VEC_LEN;

   logic signed [hebb_pkg::WEIGHT_W-1:0] weight_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            weight_ff[i] <= '0;
         end
      end else if (wr_en) begin
         weight_ff[addr] <= wr_data;
      end
   end

   assign rd_data = weight_ff[addr];

endmodule
